### rtl/core/cbd_pkg.sv
// cbd_pkg: shared widths, register map and stage types for the correlation bit demodulator
// no dependencies; every other rtl/core file refers to it by scoped names

package cbd_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int ACC_WIDTH    = 40;
    localparam int PROD_WIDTH   = 2 * SAMPLE_WIDTH;
    localparam int METRIC_WIDTH = 40;
    localparam int THRESH_WIDTH = 40;
    localparam int SPB_WIDTH    = 8;

    localparam int APB_DATA_WIDTH = 64;
    localparam int APB_ADDR_WIDTH = 5;
    localparam int REG_SEL_LSB    = 3;
    localparam int REG_SEL_WIDTH  = APB_ADDR_WIDTH - REG_SEL_LSB;

    localparam logic [SPB_WIDTH-1:0] SPB_RESET = SPB_WIDTH'(40);

    typedef enum logic [REG_SEL_WIDTH-1:0] {
        REG_MODE      = 2'd0,
        REG_SPB       = 2'd1,
        REG_THRESHOLD = 2'd2,
        REG_UNUSED    = 2'd3
    } reg_sel_t;

    typedef enum logic {
        MODE_SINGLE = 1'b0,
        MODE_DUAL   = 1'b1
    } mode_t;

    typedef struct packed {
        mode_t                           mode;
        logic [SPB_WIDTH-1:0]            samples_per_bit;
        logic signed [THRESH_WIDTH-1:0]  decision_threshold;
    } cfg_t;

    typedef struct packed {
        logic                          valid;
        logic signed [ACC_WIDTH-1:0]   integral_zero;
        logic signed [ACC_WIDTH-1:0]   integral_one;
    } dump_t;

endpackage

### rtl/core/cbd_cfg.sv
// cbd_cfg: apb-style register block holding mode, period length and threshold
// depends on cbd_pkg

module cbd_cfg
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [cbd_pkg::APB_ADDR_WIDTH-1:0]   paddr,
    input  logic [cbd_pkg::APB_DATA_WIDTH-1:0]   pwdata,
    output logic [cbd_pkg::APB_DATA_WIDTH-1:0]   prdata,
    output logic                                 pready,
    output cbd_pkg::cfg_t                        cfg
);

    cbd_pkg::cfg_t    cfg_reg;
    cbd_pkg::cfg_t    cfg_next;
    cbd_pkg::reg_sel_t sel;
    logic             wr_en;

    assign sel    = cbd_pkg::reg_sel_t'(paddr[cbd_pkg::APB_ADDR_WIDTH-1:cbd_pkg::REG_SEL_LSB]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (sel)
                cbd_pkg::REG_MODE:
                    cfg_next.mode = cbd_pkg::mode_t'(pwdata[0]);
                cbd_pkg::REG_SPB:
                    cfg_next.samples_per_bit = pwdata[cbd_pkg::SPB_WIDTH-1:0];
                cbd_pkg::REG_THRESHOLD:
                    cfg_next.decision_threshold = pwdata[cbd_pkg::THRESH_WIDTH-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (sel)
            cbd_pkg::REG_MODE:
                prdata = cbd_pkg::APB_DATA_WIDTH'(cfg_reg.mode);
            cbd_pkg::REG_SPB:
                prdata = cbd_pkg::APB_DATA_WIDTH'(cfg_reg.samples_per_bit);
            cbd_pkg::REG_THRESHOLD:
                prdata = cbd_pkg::APB_DATA_WIDTH'($unsigned(cfg_reg.decision_threshold));
            default:
                prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode               <= cbd_pkg::MODE_SINGLE;
            cfg_reg.samples_per_bit    <= cbd_pkg::SPB_RESET;
            cfg_reg.decision_threshold <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

### rtl/core/cbd_correlator.sv
// cbd_correlator: input register, product register and integrate-and-dump accumulators
// depends on cbd_pkg; hands finished period integrals to the decision stage

module cbd_correlator
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    advance,
    input  logic                                    in_valid,
    input  logic signed [cbd_pkg::SAMPLE_WIDTH-1:0] rx_sample,
    input  logic signed [cbd_pkg::SAMPLE_WIDTH-1:0] ref0_sample,
    input  logic signed [cbd_pkg::SAMPLE_WIDTH-1:0] ref1_sample,
    input  logic [cbd_pkg::SPB_WIDTH-1:0]           samples_per_bit,
    output cbd_pkg::dump_t                          dump
);

    logic                                    in_valid_reg;
    logic signed [cbd_pkg::SAMPLE_WIDTH-1:0] rx_reg;
    logic signed [cbd_pkg::SAMPLE_WIDTH-1:0] ref0_reg;
    logic signed [cbd_pkg::SAMPLE_WIDTH-1:0] ref1_reg;

    logic                                    prod_valid_reg;
    logic signed [cbd_pkg::PROD_WIDTH-1:0]   prod0_reg;
    logic signed [cbd_pkg::PROD_WIDTH-1:0]   prod1_reg;

    logic signed [cbd_pkg::ACC_WIDTH-1:0]    acc0_reg;
    logic signed [cbd_pkg::ACC_WIDTH-1:0]    acc1_reg;
    logic [cbd_pkg::SPB_WIDTH-1:0]           index_reg;

    logic signed [cbd_pkg::ACC_WIDTH-1:0]    acc0_next;
    logic signed [cbd_pkg::ACC_WIDTH-1:0]    acc1_next;
    logic [cbd_pkg::SPB_WIDTH-1:0]           index_next;
    logic [cbd_pkg::SPB_WIDTH-1:0]           period;
    logic                                    period_end;

    logic                                    dump_valid_reg;
    logic signed [cbd_pkg::ACC_WIDTH-1:0]    dump_zero_reg;
    logic signed [cbd_pkg::ACC_WIDTH-1:0]    dump_one_reg;

    assign acc0_next  = acc0_reg + cbd_pkg::ACC_WIDTH'(prod0_reg);
    assign acc1_next  = acc1_reg + cbd_pkg::ACC_WIDTH'(prod1_reg);
    assign index_next = index_reg + cbd_pkg::SPB_WIDTH'(1);
    // zero period behaves as one
    assign period     = (samples_per_bit == '0) ? cbd_pkg::SPB_WIDTH'(1) : samples_per_bit;
    assign period_end = index_next >= period;
    assign dump       = {dump_valid_reg, dump_zero_reg, dump_one_reg};

    // input and product stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            in_valid_reg   <= in_valid;
            prod_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rx_reg    <= rx_sample;
            ref0_reg  <= ref0_sample;
            ref1_reg  <= ref1_sample;
            prod0_reg <= rx_reg * ref0_reg;
            prod1_reg <= rx_reg * ref1_reg;
        end
    end

    // integrate and dump
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc0_reg       <= '0;
            acc1_reg       <= '0;
            index_reg      <= '0;
            dump_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            dump_valid_reg <= prod_valid_reg && period_end;
            if (prod_valid_reg)
            begin
                if (period_end)
                begin
                    acc0_reg  <= '0;
                    acc1_reg  <= '0;
                    index_reg <= '0;
                end
                else
                begin
                    acc0_reg  <= acc0_next;
                    acc1_reg  <= acc1_next;
                    index_reg <= index_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            dump_zero_reg <= acc0_next;
            dump_one_reg  <= acc1_next;
        end
    end

endmodule

### rtl/core/cbd_decision.sv
// cbd_decision: forms the period metric, compares it with the threshold, holds the result beat
// depends on cbd_pkg; fed by cbd_correlator

module cbd_decision
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     advance,
    input  cbd_pkg::dump_t                           dump,
    input  cbd_pkg::cfg_t                            cfg,
    output logic                                     out_valid,
    output logic                                     bit_value,
    output logic signed [cbd_pkg::METRIC_WIDTH-1:0]  decision_metric
);

    logic signed [cbd_pkg::ACC_WIDTH-1:0]    metric;
    logic                                    bit_next;
    logic                                    out_valid_reg;
    logic                                    bit_reg;
    logic signed [cbd_pkg::METRIC_WIDTH-1:0] metric_reg;

    assign metric = (cfg.mode == cbd_pkg::MODE_DUAL)
                  ? dump.integral_one - dump.integral_zero
                  : dump.integral_zero;
    assign bit_next = metric > cfg.decision_threshold;

    assign out_valid       = out_valid_reg;
    assign bit_value       = bit_reg;
    assign decision_metric = metric_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= dump.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            bit_reg    <= bit_next;
            metric_reg <= cbd_pkg::METRIC_WIDTH'(metric);
        end
    end

endmodule

### rtl/core/correlation_bit_demodulator_core.sv
// correlation_bit_demodulator_core: integrate-and-dump correlation demodulator top level
// depends on cbd_pkg, cbd_cfg, cbd_correlator, cbd_decision
//
// One sample beat is taken every clock cycle while the result beat is not held by out_stall.
// Each beat passes an input register, a product register (two 16x16 multipliers), the
// accumulate stage and the decision register. At the end of every period of samples_per_bit
// samples (zero counts as one) one result beat gives the decided bit and the metric; single
// mode uses the ref0 integral, dual mode the ref1 integral minus the ref0 integral, and the
// bit is one when the metric is greater than the signed threshold. A held result stalls the
// whole pipeline.
// Registers (64-bit apb data): mode at 0x00, samples_per_bit at 0x08, threshold at 0x10.

module correlation_bit_demodulator_core
(
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  logic                                     psel,
    input  logic                                     penable,
    input  logic                                     pwrite,
    input  logic [cbd_pkg::APB_ADDR_WIDTH-1:0]       paddr,
    input  logic [cbd_pkg::APB_DATA_WIDTH-1:0]       pwdata,
    output logic [cbd_pkg::APB_DATA_WIDTH-1:0]       prdata,
    output logic                                     pready,
    input  logic                                     in_valid,
    output logic                                     in_stall,
    input  logic signed [cbd_pkg::SAMPLE_WIDTH-1:0]  rx_sample,
    input  logic signed [cbd_pkg::SAMPLE_WIDTH-1:0]  ref0_sample,
    input  logic signed [cbd_pkg::SAMPLE_WIDTH-1:0]  ref1_sample,
    output logic                                     out_valid,
    input  logic                                     out_stall,
    output logic                                     bit_value,
    output logic signed [cbd_pkg::METRIC_WIDTH-1:0]  decision_metric
);

    cbd_pkg::cfg_t  cfg;
    cbd_pkg::dump_t dump;
    logic           advance;

    // pipeline moves unless a result beat is waiting
    assign advance  = !(out_valid && out_stall);
    assign in_stall = !advance;

    cbd_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cbd_correlator u_correlator
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .advance         (advance),
        .in_valid        (in_valid),
        .rx_sample       (rx_sample),
        .ref0_sample     (ref0_sample),
        .ref1_sample     (ref1_sample),
        .samples_per_bit (cfg.samples_per_bit),
        .dump            (dump)
    );

    cbd_decision u_decision
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .advance         (advance),
        .dump            (dump),
        .cfg             (cfg),
        .out_valid       (out_valid),
        .bit_value       (bit_value),
        .decision_metric (decision_metric)
    );

endmodule

### dv/tb.sv
// tb: self-checking testbench for correlation_bit_demodulator_core, integrate-and-dump bit decisions
// depends on cbd_pkg and the rtl/core sources; predicts each bit and metric from the sample beats
// directed corner cases, a full 255-sample period, then randomized settings with random idling

`timescale 1ns / 100ps

module tb;
    import cbd_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PIPE_CYCLES = 8;
    localparam int RANDOM_PHASES = 9;
    localparam int PHASE_BEATS = 95;

    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
    localparam logic signed [THRESH_WIDTH-1:0] THRESH_MAX = {1'b0, {(THRESH_WIDTH-1){1'b1}}};
    localparam logic signed [THRESH_WIDTH-1:0] THRESH_MIN = {1'b1, {(THRESH_WIDTH-1){1'b0}}};

    typedef struct packed {
        logic                           bit_value;
        logic signed [METRIC_WIDTH-1:0] metric;
    } bit_decision_t;

    logic                             clk;
    logic                             rst_n;
    logic                             psel;
    logic                             penable;
    logic                             pwrite;
    logic [APB_ADDR_WIDTH-1:0]        paddr;
    logic [APB_DATA_WIDTH-1:0]        pwdata;
    logic [APB_DATA_WIDTH-1:0]        prdata;
    logic                             pready;
    logic                             in_valid;
    logic                             in_stall;
    logic signed [SAMPLE_WIDTH-1:0]   rx_sample;
    logic signed [SAMPLE_WIDTH-1:0]   ref0_sample;
    logic signed [SAMPLE_WIDTH-1:0]   ref1_sample;
    logic                             out_valid;
    logic                             out_stall;
    logic                             bit_value;
    logic signed [METRIC_WIDTH-1:0]   decision_metric;

    bit_decision_t                    expected_bits[$];
    mode_t                            cur_mode;
    logic [SPB_WIDTH-1:0]             cur_spb;
    logic signed [THRESH_WIDTH-1:0]   cur_thresh;
    logic signed [ACC_WIDTH-1:0]      integ_zero;
    logic signed [ACC_WIDTH-1:0]      integ_one;
    logic [SPB_WIDTH-1:0]             period_count;

    int errors = 0;
    int samples_sent = 0;
    int bits_checked = 0;
    int cycle_count = 0;
    bit idling;
    bit stall_hold;

    correlation_bit_demodulator_core dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .rx_sample       (rx_sample),
        .ref0_sample     (ref0_sample),
        .ref1_sample     (ref1_sample),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .bit_value       (bit_value),
        .decision_metric (decision_metric)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("correlation_bit_demodulator_core test failed");
            $finish;
        end
    end

    // result side back-pressure bursts
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (idling && !stall_hold && $urandom_range(0, 7) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin : bit_checker
        bit_decision_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_bits.size() == 0)
            begin
                $error("result beat with no expected bit: bit_value %0b decision_metric %0d",
                       bit_value, decision_metric);
                errors++;
            end
            else
            begin
                want = expected_bits.pop_front();
                if (bit_value !== want.bit_value)
                begin
                    $error("bit_value mismatch: expected %0b, actual %0b",
                           want.bit_value, bit_value);
                    errors++;
                end
                if (decision_metric !== want.metric)
                begin
                    $error("decision_metric mismatch: expected %0d, actual %0d",
                           want.metric, decision_metric);
                    errors++;
                end
                bits_checked++;
            end
        end
    end

    task automatic integrate_sample(input logic signed [SAMPLE_WIDTH-1:0] rx,
                                    input logic signed [SAMPLE_WIDTH-1:0] zero_ref,
                                    input logic signed [SAMPLE_WIDTH-1:0] one_ref);
        logic signed [PROD_WIDTH-1:0] prod_zero;
        logic signed [PROD_WIDTH-1:0] prod_one;
        logic [SPB_WIDTH-1:0]         period;
        bit_decision_t                decision;
        prod_zero = rx * zero_ref;
        prod_one = rx * one_ref;
        integ_zero = integ_zero + prod_zero;
        integ_one = integ_one + prod_one;
        period_count = period_count + 1'b1;
        period = (cur_spb == '0) ? SPB_WIDTH'(1) : cur_spb;
        if (period_count >= period)
        begin
            decision.metric = (cur_mode == MODE_DUAL) ? integ_one - integ_zero : integ_zero;
            decision.bit_value = (decision.metric > cur_thresh);
            expected_bits = {expected_bits, decision};
            integ_zero = '0;
            integ_one = '0;
            period_count = '0;
        end
    endtask

    task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] rx,
                               input logic signed [SAMPLE_WIDTH-1:0] zero_ref,
                               input logic signed [SAMPLE_WIDTH-1:0] one_ref);
        bit taken;
        if (idling && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_sample <= rx;
        ref0_sample <= zero_ref;
        ref1_sample <= one_ref;
        do
        begin
            @(negedge clk);
            taken = !in_stall;
            @(posedge clk);
        end
        while (!taken);
        integrate_sample(rx, zero_ref, one_ref);
        samples_sent++;
    endtask

    // drain every expected bit, then let partial-period beats clear the pipeline
    task automatic settle();
        in_valid <= 1'b0;
        stall_hold = 1'b1;
        do
        begin
            @(negedge clk);
        end
        while (out_stall || expected_bits.size() != 0);
        repeat (PIPE_CYCLES) @(posedge clk);
        stall_hold = 1'b0;
    endtask

    task automatic write_reg(input reg_sel_t sel, input logic [APB_DATA_WIDTH-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {sel, {REG_SEL_LSB{1'b0}}};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        case (sel)
            REG_MODE:      cur_mode = mode_t'(data[0]);
            REG_SPB:       cur_spb = data[SPB_WIDTH-1:0];
            REG_THRESHOLD: cur_thresh = data[THRESH_WIDTH-1:0];
            default:       ;
        endcase
    endtask

    task automatic check_reg(input reg_sel_t sel, input logic [APB_DATA_WIDTH-1:0] want,
                             input int width);
        logic [APB_DATA_WIDTH-1:0] got;
        logic [APB_DATA_WIDTH-1:0] mask;
        mask = (width >= APB_DATA_WIDTH) ? '1 : ((APB_DATA_WIDTH'(1) << width) - 1'b1);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {sel, {REG_SEL_LSB{1'b0}}};
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        got = prdata;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if ((got & mask) !== (want & mask))
        begin
            $error("%s readback mismatch: expected %0h, actual %0h",
                   sel.name(), want & mask, got & mask);
            errors++;
        end
    endtask

    task automatic apply_settings(input mode_t mode, input logic [SPB_WIDTH-1:0] spb,
                                  input logic signed [THRESH_WIDTH-1:0] thresh);
        write_reg(REG_MODE, APB_DATA_WIDTH'(mode));
        write_reg(REG_SPB, APB_DATA_WIDTH'(spb));
        write_reg(REG_THRESHOLD, APB_DATA_WIDTH'(thresh));
        check_reg(REG_MODE, APB_DATA_WIDTH'(mode), 1);
        check_reg(REG_SPB, APB_DATA_WIDTH'(spb), SPB_WIDTH);
        check_reg(REG_THRESHOLD, APB_DATA_WIDTH'(thresh), THRESH_WIDTH);
    endtask

    function automatic logic signed [SAMPLE_WIDTH-1:0] pick_sample();
        case ($urandom_range(0, 11))
            0:       return SAMPLE_MIN;
            1:       return SAMPLE_MAX;
            2:       return '0;
            3:       return '1;
            default: return SAMPLE_WIDTH'($urandom);
        endcase
    endfunction

    function automatic logic signed [THRESH_WIDTH-1:0] pick_thresh();
        logic signed [63:0] raw;
        raw = {$urandom, $urandom};
        return THRESH_WIDTH'(raw >>> $urandom_range(24, 40));
    endfunction

    task automatic test_reset_values();
        check_reg(REG_MODE, APB_DATA_WIDTH'(MODE_SINGLE), 1);
        check_reg(REG_SPB, APB_DATA_WIDTH'(SPB_RESET), SPB_WIDTH);
        check_reg(REG_THRESHOLD, '0, THRESH_WIDTH);
    endtask

    task automatic test_zero_period();
        apply_settings(MODE_SINGLE, '0, '0);
        send_sample(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN);
        send_sample(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX);
        send_sample('0, '0, '0);
        send_sample(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN);
    endtask

    task automatic test_dual_difference();
        settle();
        apply_settings(MODE_DUAL, 8'd3, '0);
        send_sample(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN);
        send_sample(SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX);
        send_sample(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX);
        settle();
        apply_settings(MODE_DUAL, 8'd1, THRESH_MAX);
        send_sample(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN);
        settle();
        apply_settings(MODE_DUAL, 8'd1, THRESH_MIN);
        send_sample('0, '0, '0);
        send_sample(SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN);
    endtask

    task automatic test_single_ignores_ref1();
        settle();
        apply_settings(MODE_SINGLE, 8'd2, '1);
        send_sample(16'sd1, '1, SAMPLE_MAX);
        send_sample('1, 16'sd1, SAMPLE_MIN);
    endtask

    task automatic test_period_shortened();
        settle();
        apply_settings(MODE_SINGLE, 8'd8, '0);
        repeat (5) send_sample(pick_sample(), pick_sample(), pick_sample());
        settle();
        apply_settings(MODE_SINGLE, 8'd3, '0);
        repeat (4) send_sample(pick_sample(), pick_sample(), pick_sample());
    endtask

    // full-length period pushing the dual metric toward its positive limit
    task automatic test_long_period();
        settle();
        apply_settings(MODE_DUAL, 8'd255, pick_thresh());
        repeat (255)
        begin
            if ($urandom_range(0, 9) != 0)
                send_sample(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MIN);
            else
                send_sample(pick_sample(), pick_sample(), pick_sample());
        end
    endtask

    task automatic test_random_traffic();
        logic [SPB_WIDTH-1:0]           spb;
        logic signed [THRESH_WIDTH-1:0] thresh;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            settle();
            case (phase)
                0:       spb = '0;
                1:       spb = 8'd1;
                2:       spb = SPB_RESET;
                default: spb = SPB_WIDTH'($urandom_range(2, 24));
            endcase
            case (phase)
                3:       thresh = THRESH_MIN;
                4:       thresh = THRESH_MAX;
                5:       thresh = '0;
                default: thresh = pick_thresh();
            endcase
            apply_settings(mode_t'(phase[0]), spb, thresh);
            idling = (phase != RANDOM_PHASES - 1);
            repeat (PHASE_BEATS) send_sample(pick_sample(), pick_sample(), pick_sample());
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_valid = 1'b0;
        rx_sample = '0;
        ref0_sample = '0;
        ref1_sample = '0;
        out_stall = 1'b0;
        idling = 1'b1;
        stall_hold = 1'b0;
        cur_mode = MODE_SINGLE;
        cur_spb = SPB_RESET;
        cur_thresh = '0;
        integ_zero = '0;
        integ_one = '0;
        period_count = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_zero_period();
        test_dual_difference();
        test_single_ignores_ref1();
        test_period_shortened();
        test_long_period();
        test_random_traffic();
        settle();

        $display("sent %0d sample beats: corner values, a full 255-sample period, random settings",
                 samples_sent);
        $display("checked %0d decided bits across single and dual correlator modes", bits_checked);
        if (errors == 0)
            $display("correlation_bit_demodulator_core test passed");
        else
            $display("correlation_bit_demodulator_core test failed");
        $finish;
    end

endmodule

### files.f
rtl/core/cbd_pkg.sv
rtl/core/cbd_cfg.sv
rtl/core/cbd_correlator.sv
rtl/core/cbd_decision.sv
rtl/core/correlation_bit_demodulator_core.sv
dv/tb.sv
